@@ src/histogram_clip_range_top_macros.svh @@
// Assertion macros for the histogram clip range block.
`ifndef HISTOGRAM_CLIP_RANGE_TOP_MACROS_SVH
`define HISTOGRAM_CLIP_RANGE_TOP_MACROS_SVH

// check a property on every clock edge once out of reset
`define HCR_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define HCR_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/hcr_pkg.sv @@
// Package: sizes and constants of the histogram clip range block.
package hcr_pkg;

    localparam int BINS       = 256;
    localparam int COUNT_BITS = 32;

    localparam int IN_W     = 32;
    localparam int STORE_W  = (COUNT_BITS < IN_W) ? COUNT_BITS : IN_W;
    localparam int IDX_W    = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CNT_W    = $clog2(BINS + 1);
    localparam int OUT_IDX_W = 8;
    localparam int TOTAL_W  = 40;
    localparam int FRAC_W   = 15;
    localparam int Q_SHIFT  = 16;
    localparam int HALF_W   = TOTAL_W / 2;
    localparam int PROD_W   = FRAC_W + HALF_W;
    localparam int RND_W    = TOTAL_W + FRAC_W + 1;
    localparam int CUM_W    = STORE_W + IDX_W;
    localparam int CMP_W    = (CUM_W > TOTAL_W) ? CUM_W : TOTAL_W;

    localparam logic [FRAC_W-1:0]  FRAC_MAX  = FRAC_W'(32112);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [RND_W-1:0]   RND_HALF  = RND_W'(1) << (Q_SHIFT - 1);

endpackage

@@ src/hcr_if.sv @@
// Interfaces: bin item input channel and clip range result channel.
interface hcr_in_if import hcr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IN_W-1:0]  bin_value;
    logic             last_bin;

    modport source (output valid, output bin_value, output last_bin, input ready);
    modport sink   (input valid, input bin_value, input last_bin, output ready);
endinterface

interface hcr_out_if import hcr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] low_bin;
    logic [OUT_IDX_W-1:0] high_bin;
    logic                 has_data;
    logic [TOTAL_W-1:0]   total_count;

    modport source (output valid, output low_bin, output high_bin, output has_data,
                    output total_count, input ready);
    modport sink   (input valid, input low_bin, input high_bin, input has_data,
                    input total_count, output ready);
endinterface

@@ src/histogram_clip_range_top.sv @@
// Top level: histogram store, clip count and two-sided percentile scan.
// Loading takes one item per cycle into a 256-entry bin memory (one write port,
// one read port). After the last bin the clip count is formed (S_MUL, S_RND),
// then the low and high scans run (one memory read per cycle) and the result
// is registered to the output.
// Synchronous reset clears counters and control; the bin memory is not cleared.
`include "histogram_clip_range_top_macros.svh"

module histogram_clip_range_top import hcr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [FRAC_W-1:0]  i_cfg_wdata,
    hcr_in_if.sink             i_in,
    hcr_out_if.source          o_out
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_MUL,
        S_RND,
        S_SCAN_LO,
        S_SCAN_HI,
        S_DONE
    } t_state_e;

    t_state_e             r_state;
    logic [FRAC_W-1:0]    r_frac;
    logic [CNT_W-1:0]     r_count;
    logic [TOTAL_W-1:0]   r_total;
    logic [PROD_W-1:0]    r_pp_lo;
    logic [PROD_W-1:0]    r_pp_hi;
    logic [TOTAL_W-1:0]   r_clip;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_iss_done;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [CMP_W-1:0]     r_cum;
    logic [IDX_W-1:0]     r_lo;
    logic                 r_has_data;
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_lo;
    logic [OUT_IDX_W-1:0] r_out_hi;
    logic                 r_out_has;
    logic [TOTAL_W-1:0]   r_out_total;

    logic [STORE_W-1:0]   mem [BINS];
    logic [STORE_W-1:0]   r_rd_data;

    logic                 in_acc;
    logic                 mem_we;
    logic [TOTAL_W:0]     n_total;
    logic [FRAC_W-1:0]    frac_c;
    logic [RND_W-1:0]     clip_sum;
    logic [CMP_W-1:0]     cum_sum;
    logic                 hit;
    logic [CNT_W-1:0]     count_m1;
    logic [IDX_W-1:0]     last_idx;
    logic                 out_free;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign mem_we     = in_acc && (r_count < CNT_W'(BINS));
    assign n_total    = {1'b0, r_total} + (TOTAL_W + 1)'(STORE_W'(i_in.bin_value));
    assign frac_c     = (r_frac > FRAC_MAX) ? FRAC_MAX : r_frac;
    assign clip_sum   = (RND_W'(r_pp_hi) << HALF_W) + RND_W'(r_pp_lo) + RND_HALF;
    assign cum_sum    = r_cum + CMP_W'(r_rd_data);
    assign hit        = cum_sum > CMP_W'(r_clip);
    assign count_m1   = r_count - CNT_W'(1);
    assign last_idx   = count_m1[IDX_W-1:0];
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.low_bin     = r_out_lo;
    assign o_out.high_bin    = r_out_hi;
    assign o_out.has_data    = r_out_has;
    assign o_out.total_count = r_out_total;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= STORE_W'(i_in.bin_value);
        end
        r_rd_data <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= '0;
        end else if (i_cfg_we) begin
            r_frac <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_idx       <= '0;
            r_iss_done  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (mem_we) begin
                        r_count <= r_count + CNT_W'(1);
                        r_total <= n_total[TOTAL_W] ? TOTAL_MAX : n_total[TOTAL_W-1:0];
                    end
                    if (in_acc && i_in.last_bin) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_pp_lo <= PROD_W'(frac_c) * PROD_W'(r_total[HALF_W-1:0]);
                    r_pp_hi <= PROD_W'(frac_c) * PROD_W'(r_total[TOTAL_W-1:HALF_W]);
                    if (r_total == '0) begin
                        r_lo       <= '0;
                        r_has_data <= 1'b0;
                        r_rd_idx   <= last_idx;
                        r_state    <= S_DONE;
                    end else begin
                        r_has_data <= 1'b1;
                        r_state    <= S_RND;
                    end
                end
                S_RND: begin
                    r_clip     <= clip_sum[Q_SHIFT+TOTAL_W-1:Q_SHIFT];
                    r_idx      <= '0;
                    r_iss_done <= 1'b0;
                    r_rd_vld   <= 1'b0;
                    r_cum      <= '0;
                    r_state    <= S_SCAN_LO;
                end
                S_SCAN_LO: begin
                    if (r_rd_vld && (hit || r_rd_idx == last_idx)) begin
                        r_lo       <= r_rd_idx;
                        r_idx      <= last_idx;
                        r_iss_done <= 1'b0;
                        r_rd_vld   <= 1'b0;
                        r_cum      <= '0;
                        r_state    <= S_SCAN_HI;
                    end else begin
                        r_rd_vld <= !r_iss_done;
                        r_rd_idx <= r_idx;
                        if (!r_iss_done) begin
                            if (r_idx == last_idx) begin
                                r_iss_done <= 1'b1;
                            end else begin
                                r_idx <= r_idx + IDX_W'(1);
                            end
                        end
                        if (r_rd_vld) begin
                            r_cum <= cum_sum;
                        end
                    end
                end
                S_SCAN_HI: begin
                    if (r_rd_vld && (hit || r_rd_idx == '0)) begin
                        r_rd_idx <= (r_rd_idx < r_lo) ? r_lo : r_rd_idx;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_rd_vld <= !r_iss_done;
                        r_rd_idx <= r_idx;
                        if (!r_iss_done) begin
                            if (r_idx == '0) begin
                                r_iss_done <= 1'b1;
                            end else begin
                                r_idx <= r_idx - IDX_W'(1);
                            end
                        end
                        if (r_rd_vld) begin
                            r_cum <= cum_sum;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_lo    <= OUT_IDX_W'(r_lo);
                        r_out_hi    <= OUT_IDX_W'(r_rd_idx);
                        r_out_has   <= r_has_data;
                        r_out_total <= r_total;
                        r_count     <= '0;
                        r_total     <= '0;
                        r_idx       <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    `HCR_ASSERT_RUN(a_order, r_out_valid |-> r_out_hi >= r_out_lo, "bin order")
    `HCR_ASSERT_RUN(a_empty, r_out_valid && !r_out_has |-> r_out_total == '0, "empty total")
    `HCR_ASSERT_ALL(a_count, !i_rst_n || r_count <= CNT_W'(BINS), "over capacity")
    `HCR_ASSERT_RUN(a_result_src, $rose(r_out_valid) |-> $past(r_state == S_DONE), "no scan")

endmodule

@@ tb/histogram_clip_range_top_tb.sv @@
// Testbench: histogram clip range top, self-checking with directed and random histograms.
module histogram_clip_range_top_tb;
    import hcr_pkg::*;

    typedef struct packed {
        logic [IN_W-1:0] count;
        logic            last;
    } t_bin_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] low_bin;
        logic [OUT_IDX_W-1:0] high_bin;
        logic                 has_data;
        logic [TOTAL_W-1:0]   total_count;
    } t_clip_range;

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_ZERO,
        FILL_SPIKY,
        FILL_NEAR_MAX
    } t_fill_style;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FRAC_W-1:0]  i_cfg_wdata;

    hcr_in_if  bins_ch ();
    hcr_out_if range_ch ();

    histogram_clip_range_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (bins_ch),
        .o_out       (range_ch)
    );

    t_bin_item    pending_bins[$];
    t_clip_range  expected_ranges[$];
    t_bin_item    next_bin;

    logic [STORE_W-1:0] hist_mem [BINS];
    int                 hist_len;
    logic [TOTAL_W:0]   hist_sum;
    logic [FRAC_W-1:0]  clip_frac;

    int send_idle_pct;
    int recv_stall_pct;
    int bins_queued;
    int bins_taken;
    int hists_queued;
    int ranges_checked;
    int frac_writes;
    int mismatches;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("histogram_clip_range top: timeout after %0d items taken", bins_taken);
        $display("histogram_clip_range_top regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic t_clip_range compute_range();
        t_clip_range r;
        logic [63:0] frac;
        logic [63:0] clip;
        logic [63:0] cum;
        int          n;
        int          lo;
        int          hi;
        r = '0;
        n = hist_len;
        if (n == 0)
            return r;
        if (hist_sum == 0) begin
            r.high_bin = OUT_IDX_W'(n - 1);
            return r;
        end
        frac = (clip_frac > FRAC_MAX) ? 64'(FRAC_MAX) : 64'(clip_frac);
        clip = (frac * 64'(hist_sum) + 64'd32768) >> Q_SHIFT;
        lo = 0;
        cum = 0;
        for (int i = 0; i < n; i++) begin
            cum += 64'(hist_mem[i]);
            lo = i;
            if (cum > clip)
                break;
        end
        hi = n - 1;
        cum = 0;
        for (int i = n - 1; i >= 0; i--) begin
            cum += 64'(hist_mem[i]);
            hi = i;
            if (cum > clip)
                break;
        end
        if (hi < lo)
            hi = lo;
        r.low_bin     = OUT_IDX_W'(lo);
        r.high_bin    = OUT_IDX_W'(hi);
        r.has_data    = 1'b1;
        r.total_count = hist_sum[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic fold_bin(input logic [IN_W-1:0] count, input logic last);
        logic [STORE_W-1:0] v;
        v = count[STORE_W-1:0];
        if (hist_len < BINS) begin
            hist_mem[hist_len] = v;
            hist_len++;
            hist_sum = hist_sum + (TOTAL_W + 1)'(v);
            if (hist_sum > (TOTAL_W + 1)'(TOTAL_MAX))
                hist_sum = (TOTAL_W + 1)'(TOTAL_MAX);
        end
        if (last) begin
            expected_ranges.insert(expected_ranges.size(), compute_range());
            hist_len = 0;
            hist_sum = '0;
        end
    endtask

    task automatic check_range();
        t_clip_range want;
        if (expected_ranges.size() == 0) begin
            report_mismatch("range with none expected", 64'(range_ch.low_bin), 64'd0);
            return;
        end
        want = expected_ranges.pop_front();
        if (range_ch.low_bin !== want.low_bin)
            report_mismatch("low_bin", 64'(range_ch.low_bin), 64'(want.low_bin));
        if (range_ch.high_bin !== want.high_bin)
            report_mismatch("high_bin", 64'(range_ch.high_bin), 64'(want.high_bin));
        if (range_ch.has_data !== want.has_data)
            report_mismatch("has_data", 64'(range_ch.has_data), 64'(want.has_data));
        if (range_ch.total_count !== want.total_count)
            report_mismatch("total_count", 64'(range_ch.total_count), 64'(want.total_count));
        ranges_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bins_ch.valid     <= 1'b0;
            bins_ch.bin_value <= '0;
            bins_ch.last_bin  <= 1'b0;
        end else begin
            if (bins_ch.valid && bins_ch.ready) begin
                fold_bin(bins_ch.bin_value, bins_ch.last_bin);
                bins_taken++;
            end
            if (!bins_ch.valid || bins_ch.ready) begin
                if (pending_bins.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_bin = pending_bins.pop_front();
                    bins_ch.valid     <= 1'b1;
                    bins_ch.bin_value <= next_bin.count;
                    bins_ch.last_bin  <= next_bin.last;
                end else begin
                    bins_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            range_ch.ready <= 1'b0;
        end else begin
            if (range_ch.valid && range_ch.ready)
                check_range();
            range_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [IN_W-1:0] make_count(input t_fill_style style);
        case (style)
            FILL_FULL:     return IN_W'($urandom);
            FILL_SMALL:    return IN_W'($urandom_range(15));
            FILL_ZERO:     return '0;
            FILL_SPIKY: begin
                if ($urandom_range(3) == 0)
                    return IN_W'($urandom);
                return IN_W'($urandom_range(3));
            end
            default:       return {IN_W{1'b1}} - IN_W'($urandom_range(3));
        endcase
    endfunction

    task automatic queue_bins(input logic [IN_W-1:0] counts[$]);
        foreach (counts[i])
            pending_bins.insert(pending_bins.size(),
                                t_bin_item'{count: counts[i], last: (i == counts.size() - 1)});
        bins_queued += counts.size();
        hists_queued++;
    endtask

    task automatic queue_random_hist(input int n);
        logic [IN_W-1:0] counts[$];
        t_fill_style     style;
        style = t_fill_style'($urandom_range(FILL_NEAR_MAX));
        for (int i = 0; i < n; i++)
            counts.insert(counts.size(), make_count(style));
        queue_bins(counts);
    endtask

    task automatic wait_drained();
        while (bins_taken != bins_queued || expected_ranges.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_clip_frac(input logic [FRAC_W-1:0] frac);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= frac;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        clip_frac = frac;
        frac_writes++;
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(input logic [FRAC_W-1:0] frac, input int send_pct,
                                    input int recv_pct, input int big_bins);
        int phase_bins;
        int n;
        wait_drained();
        write_clip_frac(frac);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        phase_bins = 0;
        if (big_bins > 0) begin
            queue_random_hist(big_bins);
            phase_bins += big_bins;
        end
        while (phase_bins < 245) begin
            if ($urandom_range(15) == 0)
                n = $urandom_range(13, 64);
            else
                n = $urandom_range(1, 12);
            queue_random_hist(n);
            phase_bins += n;
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        hist_len       = 0;
        hist_sum       = '0;
        clip_frac      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        bins_queued    = 0;
        bins_taken     = 0;
        hists_queued   = 0;
        ranges_checked = 0;
        frac_writes    = 0;
        mismatches     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_clip_frac('0);
        queue_bins('{32'd0});
        queue_bins('{32'd0, 32'd0, 32'd0, 32'd0});
        queue_bins('{32'hFFFF_FFFF});
        queue_bins('{32'd0, 32'd0, 32'd9, 32'd0, 32'd4, 32'd0});

        wait_drained();
        write_clip_frac({FRAC_W{1'b1}});
        queue_bins('{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1});
        queue_bins('{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF});

        wait_drained();
        write_clip_frac(FRAC_MAX);
        queue_bins('{32'd10, 32'd0, 32'd0, 32'd10});

        run_random_phase(FRAC_W'($urandom), 0, 0, BINS);
        run_random_phase(FRAC_MAX, 84, 0, 0);
        run_random_phase('0, 0, 84, BINS + 2);
        run_random_phase(FRAC_W'($urandom_range(32112)), 7, 7, 0);
        run_random_phase({FRAC_W{1'b1}}, 0, 0, 0);

        wait_drained();
        repeat (2 * BINS + 16) @(negedge i_clk);
        if (expected_ranges.size() != 0)
            report_mismatch("ranges never produced", 64'(expected_ranges.size()), 64'd0);

        $display("Covered %0d bin items in %0d histograms, %0d clip ranges checked,",
                 bins_taken, hists_queued, ranges_checked);
        $display("across %0d clip fraction settings and four idle/stall mixes.", frac_writes);
        if (mismatches == 0) begin
            $display("histogram_clip_range_top regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("histogram_clip_range_top regression: fail");
        end
        $finish;
    end

endmodule
